// File: hw/rtl/sclc_pkg.sv
// Package for the sector cache LRU controller.
// Holds the line count, the request and result beat types and the operation codes.
// Depends on nothing.
package sclc_pkg;

	localparam int LINES = 64;
	localparam int LINE_W = $clog2(LINES);
	localparam int CNT_W = LINE_W + 1;
	localparam int LINE_FIELD_W = 6;
	localparam int STAMP_W = 64;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_PREFETCH = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] device;
		logic [31:0] sector;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [LINE_FIELD_W-1:0] line;
		logic fill_needed;
		logic writeback_needed;
		logic [1:0] writeback_device;
		logic [31:0] writeback_sector;
		logic skipped;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [1:0] device;
		logic [31:0] sector;
	} tag_t;

endpackage

// File: hw/rtl/sector_cache_lru_controller.sv
// Sector cache LRU controller: tags, valid and dirty bits, use stamps and the scan sequencer.
// Depends on sclc_pkg for the line count, beat types and operation codes.
//
// Requests arrive on req_valid/req_ready, one beat each with an operation, a device and a
// sector. Results leave on rsp_valid/rsp_ready through a single output register, so a
// finished result may wait there while the next request is taken. The register
// disk_sectors is written through cfg_we/cfg_wdata; the user must write it only while the block
// is idle, as the block itself does not enforce this. A read, write or prefetch scans all
// LINES lines, one line per cycle through the registered read port of the tag and stamp
// memories, then decides. A prefetch whose sector is at or beyond disk_sectors is not
// scanned: it goes to ST_SKIP and offers a skipped result. A flush walks the lines in order
// and emits one beat per dirty line with the final beat marked last; a flush with no dirty
// line gives no beat. Only one request is worked on at a time.
// Reset clears all valid and dirty bits, the access clock and disk_sectors; the tag and
// stamp memories need no clearing. A stalled receiver holds the sequencer at its next
// result beat and no further request is taken until the current one is done.
module sector_cache_lru_controller (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input sclc_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output sclc_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [31:0] cfg_wdata
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_SKIP = 6'b001000,
		ST_FL_SCAN = 6'b010000,
		ST_FL_RD = 6'b100000
	} state_t;

	state_t state_q;
	logic [sclc_pkg::CNT_W-1:0] cnt_q;
	logic [sclc_pkg::LINE_W-1:0] cnt_idx;
	logic cnt_done;
	logic [sclc_pkg::LINES-1:0] valid_q;
	logic [sclc_pkg::LINES-1:0] dirty_q;
	logic [sclc_pkg::STAMP_W-1:0] clock_q;
	logic [31:0] disk_q;
	sclc_pkg::req_t req_q;

	sclc_pkg::tag_t tag_mem [sclc_pkg::LINES];
	logic [sclc_pkg::STAMP_W-1:0] stamp_mem [sclc_pkg::LINES];
	sclc_pkg::tag_t tag_rd_s1;
	logic [sclc_pkg::STAMP_W-1:0] stamp_rd_s1;
	logic rd_vld_s1;
	logic [sclc_pkg::LINE_W-1:0] rd_idx_s1;

	logic hit_found_q;
	logic [sclc_pkg::LINE_W-1:0] hit_idx_q;
	logic inv_found_q;
	logic [sclc_pkg::LINE_W-1:0] inv_idx_q;
	logic best_set_q;
	logic [sclc_pkg::LINE_W-1:0] best_idx_q;
	logic [sclc_pkg::STAMP_W-1:0] best_stamp_q;
	sclc_pkg::tag_t best_tag_q;

	logic rsp_valid_q;
	sclc_pkg::rsp_t rsp_q;
	logic pend_q;
	sclc_pkg::rsp_t pend_rsp_q;

	logic out_free;
	logic rd_en;
	logic cmp_valid;
	logic cmp_match;
	logic cmp_better;
	logic [sclc_pkg::LINE_W-1:0] victim;
	logic is_miss;
	logic wb;
	logic [sclc_pkg::STAMP_W-1:0] clock_inc;
	logic rsp_load;
	sclc_pkg::rsp_t rsp_next;
	sclc_pkg::rsp_t fl_rsp;
	logic accept;
	logic fl_hit;

	assign cnt_idx = cnt_q[sclc_pkg::LINE_W-1:0];
	assign cnt_done = (cnt_q == sclc_pkg::CNT_W'(sclc_pkg::LINES));
	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign clock_inc = clock_q + sclc_pkg::STAMP_W'(1);
	assign fl_hit = !cnt_done && valid_q[cnt_idx] && dirty_q[cnt_idx];

	assign cmp_valid = valid_q[rd_idx_s1];
	assign cmp_match = cmp_valid && (tag_rd_s1.device == req_q.device)
		&& (tag_rd_s1.sector == req_q.sector);
	assign cmp_better = !best_set_q || (stamp_rd_s1 < best_stamp_q);

	assign is_miss = !hit_found_q;
	assign victim = hit_found_q ? hit_idx_q : (inv_found_q ? inv_idx_q : best_idx_q);
	assign wb = is_miss && !inv_found_q && dirty_q[best_idx_q];

	always_comb begin
		rd_en = 1'b0;
		case (state_q)
			ST_SCAN: rd_en = !cnt_done;
			ST_FL_SCAN: rd_en = fl_hit;
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		fl_rsp = '0;
		fl_rsp.line = sclc_pkg::LINE_FIELD_W'(cnt_idx);
		fl_rsp.writeback_needed = 1'b1;
		fl_rsp.writeback_device = tag_rd_s1.device;
		fl_rsp.writeback_sector = tag_rd_s1.sector;
	end

	always_comb begin
		rsp_load = 1'b0;
		rsp_next = '0;
		case (state_q)
			ST_DECIDE: begin
				rsp_load = out_free;
				rsp_next.hit = hit_found_q;
				rsp_next.line = sclc_pkg::LINE_FIELD_W'(victim);
				rsp_next.fill_needed = is_miss && (req_q.operation != sclc_pkg::OP_WRITE);
				rsp_next.writeback_needed = wb;
				rsp_next.writeback_device = wb ? best_tag_q.device : 2'd0;
				rsp_next.writeback_sector = wb ? best_tag_q.sector : 32'd0;
				rsp_next.last = 1'b1;
			end
			ST_SKIP: begin
				rsp_load = out_free;
				rsp_next.skipped = 1'b1;
				rsp_next.last = 1'b1;
			end
			ST_FL_SCAN: begin
				rsp_load = cnt_done && pend_q && out_free;
				rsp_next = pend_rsp_q;
				rsp_next.last = 1'b1;
			end
			ST_FL_RD: begin
				rsp_load = pend_q && out_free;
				rsp_next = pend_rsp_q;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			clock_q <= '0;
			disk_q <= '0;
			rd_vld_s1 <= 1'b0;
			hit_found_q <= 1'b0;
			inv_found_q <= 1'b0;
			best_set_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				disk_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1 <= rd_en && (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					hit_found_q <= 1'b0;
					inv_found_q <= 1'b0;
					best_set_q <= 1'b0;
					pend_q <= 1'b0;
					if (accept) begin
						if (req.operation == sclc_pkg::OP_FLUSH) begin
							state_q <= ST_FL_SCAN;
						end else if ((req.operation == sclc_pkg::OP_PREFETCH)
							&& (req.sector >= disk_q)) begin
							state_q <= ST_SKIP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!cnt_done) begin
						cnt_q <= cnt_q + sclc_pkg::CNT_W'(1);
					end
					if (rd_vld_s1) begin
						if (!cmp_valid && !inv_found_q) begin
							inv_found_q <= 1'b1;
						end
						if (cmp_match && !hit_found_q) begin
							hit_found_q <= 1'b1;
						end
						if (cmp_valid && cmp_better) begin
							best_set_q <= 1'b1;
						end
					end else if (cnt_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						valid_q[victim] <= 1'b1;
						if (req_q.operation == sclc_pkg::OP_WRITE) begin
							dirty_q[victim] <= 1'b1;
						end else if (is_miss) begin
							dirty_q[victim] <= 1'b0;
						end
						if (req_q.operation != sclc_pkg::OP_PREFETCH) begin
							clock_q <= clock_inc;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SKIP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FL_SCAN: begin
					if (cnt_done) begin
						if (!pend_q) begin
							state_q <= ST_IDLE;
						end else if (out_free) begin
							pend_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else if (fl_hit) begin
						state_q <= ST_FL_RD;
					end else begin
						cnt_q <= cnt_q + sclc_pkg::CNT_W'(1);
					end
				end
				ST_FL_RD: begin
					if (!pend_q || out_free) begin
						pend_q <= 1'b1;
						dirty_q[cnt_idx] <= 1'b0;
						cnt_q <= cnt_q + sclc_pkg::CNT_W'(1);
						state_q <= ST_FL_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
		rd_idx_s1 <= cnt_idx;
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (!cmp_valid && !inv_found_q) begin
				inv_idx_q <= rd_idx_s1;
			end
			if (cmp_match && !hit_found_q) begin
				hit_idx_q <= rd_idx_s1;
			end
			if (cmp_valid && cmp_better) begin
				best_idx_q <= rd_idx_s1;
				best_stamp_q <= stamp_rd_s1;
				best_tag_q <= tag_rd_s1;
			end
		end
		if ((state_q == ST_FL_RD) && (!pend_q || out_free)) begin
			pend_rsp_q <= fl_rsp;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd_s1 <= tag_mem[cnt_idx];
			stamp_rd_s1 <= stamp_mem[cnt_idx];
		end
		if ((state_q == ST_DECIDE) && out_free) begin
			if (is_miss) begin
				tag_mem[victim] <= '{device: req_q.device, sector: req_q.sector};
			end
			if (req_q.operation != sclc_pkg::OP_PREFETCH) begin
				stamp_mem[victim] <= clock_inc;
			end else if (is_miss && inv_found_q) begin
				stamp_mem[victim] <= '0;
			end
		end
	end

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("request taken while a request was still in progress");

	a_valid_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $past($countones(valid_q)))
		else $error("a cache line lost its valid bit");

	a_victim_known: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECIDE) && !hit_found_q && !inv_found_q) |-> best_set_q)
		else $error("miss with all lines valid but no oldest line found");

	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.skipped) |-> (!rsp_q.hit && !rsp_q.writeback_needed
		&& !rsp_q.fill_needed && rsp_q.last))
		else $error("skipped prefetch beat carries other flags");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the sector cache LRU controller.
// It predicts every result beat from its own copy of the tags, dirty bits and use stamps.
// Depends on sclc_pkg and the sector_cache_lru_controller RTL.
module testbench;

	localparam int POOL = 88;
	localparam int DRAIN_PAUSE = 2 * sclc_pkg::LINES + 16;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLDOFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	sclc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	sclc_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	logic cached [sclc_pkg::LINES];
	logic dirty [sclc_pkg::LINES];
	logic [1:0] tag_device [sclc_pkg::LINES];
	logic [31:0] tag_sector [sclc_pkg::LINES];
	logic [63:0] use_stamp [sclc_pkg::LINES];
	logic [63:0] access_count;
	logic [31:0] disk_limit;

	sclc_pkg::rsp_t answers_due [$];
	logic [1:0] pool_device [POOL];
	logic [31:0] pool_sector [POOL];

	int req_idle_pct = 33;
	int rsp_idle_pct = 33;
	int rsp_holdoff_request = 0;
	int failures = 0;
	int stall_cycles = 0;
	int n_requests = 0;
	int n_beats = 0;
	int n_hits = 0;
	int n_misses = 0;
	int n_evict_writebacks = 0;
	int n_flush_beats = 0;
	int n_skipped = 0;

	sector_cache_lru_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic run_cache_policy(input sclc_pkg::req_t r);
		sclc_pkg::rsp_t beat;
		sclc_pkg::rsp_t held;
		logic have_held;
		int way;
		int victim;
		beat = '0;
		have_held = 1'b0;
		held = '0;
		n_requests++;
		if (r.operation == sclc_pkg::OP_FLUSH) begin
			for (int i = 0; i < sclc_pkg::LINES; i++) begin
				if (cached[i] && dirty[i]) begin
					if (have_held)
						answers_due.push_back(held);
					held = '0;
					held.line = i[sclc_pkg::LINE_FIELD_W-1:0];
					held.writeback_needed = 1'b1;
					held.writeback_device = tag_device[i];
					held.writeback_sector = tag_sector[i];
					have_held = 1'b1;
					dirty[i] = 1'b0;
					n_flush_beats++;
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				answers_due.push_back(held);
			end
			return;
		end
		if (r.operation == sclc_pkg::OP_PREFETCH && r.sector >= disk_limit) begin
			beat.skipped = 1'b1;
			beat.last = 1'b1;
			answers_due.push_back(beat);
			n_skipped++;
			return;
		end
		way = -1;
		for (int i = 0; i < sclc_pkg::LINES; i++)
			if (way < 0 && cached[i] && tag_device[i] == r.device && tag_sector[i] == r.sector)
				way = i;
		if (way >= 0) begin
			beat.hit = 1'b1;
			n_hits++;
		end else begin
			victim = -1;
			for (int i = 0; i < sclc_pkg::LINES; i++)
				if (victim < 0 && !cached[i])
					victim = i;
			if (victim < 0) begin
				victim = 0;
				for (int i = 1; i < sclc_pkg::LINES; i++)
					if (use_stamp[i] < use_stamp[victim])
						victim = i;
			end
			way = victim;
			if (cached[way] && dirty[way]) begin
				beat.writeback_needed = 1'b1;
				beat.writeback_device = tag_device[way];
				beat.writeback_sector = tag_sector[way];
				n_evict_writebacks++;
			end
			beat.fill_needed = (r.operation != sclc_pkg::OP_WRITE);
			cached[way] = 1'b1;
			dirty[way] = 1'b0;
			tag_device[way] = r.device;
			tag_sector[way] = r.sector;
			n_misses++;
		end
		if (r.operation == sclc_pkg::OP_WRITE)
			dirty[way] = 1'b1;
		if (r.operation != sclc_pkg::OP_PREFETCH) begin
			access_count = access_count + 64'd1;
			use_stamp[way] = access_count;
		end
		beat.line = way[sclc_pkg::LINE_FIELD_W-1:0];
		beat.last = 1'b1;
		answers_due.push_back(beat);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	task automatic check_beat(input sclc_pkg::rsp_t got);
		sclc_pkg::rsp_t want;
		n_beats++;
		if (answers_due.size() == 0) begin
			$error("result beat arrived with no request waiting for it");
			failures++;
		end else begin
			want = answers_due.pop_front();
			check_field("hit", 32'(want.hit), 32'(got.hit));
			check_field("line", 32'(want.line), 32'(got.line));
			check_field("fill_needed", 32'(want.fill_needed), 32'(got.fill_needed));
			check_field("writeback_needed", 32'(want.writeback_needed),
				32'(got.writeback_needed));
			check_field("writeback_device", 32'(want.writeback_device),
				32'(got.writeback_device));
			check_field("writeback_sector", want.writeback_sector, got.writeback_sector);
			check_field("skipped", 32'(want.skipped), 32'(got.skipped));
			check_field("last", 32'(want.last), 32'(got.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sclc_pkg::LINES; i++) begin
				cached[i] = 1'b0;
				dirty[i] = 1'b0;
				tag_device[i] = '0;
				tag_sector[i] = '0;
				use_stamp[i] = '0;
			end
			access_count = '0;
			disk_limit = '0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_beat(rsp);
			if (req_valid && req_ready)
				run_cache_policy(req);
			if (cfg_we)
				disk_limit = cfg_wdata;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int holdoff_left;
		holdoff_left = 0;
		forever begin
			@(negedge clk);
			if (rsp_holdoff_request > 0) begin
				holdoff_left = rsp_holdoff_request;
				rsp_holdoff_request = 0;
			end
			if (holdoff_left > 0) begin
				rsp_ready <= 1'b0;
				holdoff_left--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	function automatic sclc_pkg::req_t make_request(input logic [1:0] op, input logic [1:0] dev,
		input logic [31:0] sec);
		sclc_pkg::req_t r;
		r.operation = op;
		r.device = dev;
		r.sector = sec;
		return r;
	endfunction

	function automatic sclc_pkg::req_t random_request();
		sclc_pkg::req_t r;
		int pick;
		int k;
		pick = $urandom_range(99);
		k = $urandom_range(POOL - 1);
		r.device = pool_device[k];
		r.sector = pool_sector[k];
		if (pick < 36)
			r.operation = sclc_pkg::OP_READ;
		else if (pick < 70)
			r.operation = sclc_pkg::OP_WRITE;
		else if (pick < 90)
			r.operation = sclc_pkg::OP_PREFETCH;
		else if (pick < 95)
			r.operation = sclc_pkg::OP_FLUSH;
		else
			r = make_request(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom());
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken,
	// with valid still high so a following beat can go out back to back.
	task automatic send_request(input sclc_pkg::req_t item);
		if ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < req_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic set_disk_sectors(input logic [31:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd0, 32'h0000_0000));
		send_request(make_request(sclc_pkg::OP_FLUSH, 2'd0, 32'h0000_0000));
		send_request(make_request(sclc_pkg::OP_READ, 2'd3, 32'hFFFF_FFFF));
		send_request(make_request(sclc_pkg::OP_READ, 2'd3, 32'hFFFF_FFFF));
		send_request(make_request(sclc_pkg::OP_WRITE, 2'd3, 32'hFFFF_FFFF));
		send_request(make_request(sclc_pkg::OP_WRITE, 2'd0, 32'h0000_0000));
		send_request(make_request(sclc_pkg::OP_READ, 2'd1, 32'h0000_0000));
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd2, 32'hFFFF_FFFF));
		send_request(make_request(sclc_pkg::OP_FLUSH, 2'd1, 32'h1234_5678));
		send_request(make_request(sclc_pkg::OP_FLUSH, 2'd2, 32'hFFFF_FFFF));
		set_disk_sectors(32'hFFFF_FFFF);
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd2, 32'hFFFF_FFFF));
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd2, 32'hFFFF_FFFE));
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd2, 32'hFFFF_FFFE));
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd1, 32'h0000_0000));
		send_request(make_request(sclc_pkg::OP_WRITE, 2'd2, 32'hFFFF_FFFE));
		set_disk_sectors(32'h8000_0000);
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd1, 32'h7FFF_FFFF));
		send_request(make_request(sclc_pkg::OP_PREFETCH, 2'd1, 32'h8000_0000));
		send_request(make_request(sclc_pkg::OP_WRITE, 2'd0, 32'hAAAA_AAAA));
		send_request(make_request(sclc_pkg::OP_READ, 2'd3, 32'h5555_5555));
		send_request(make_request(sclc_pkg::OP_FLUSH, 2'd0, 32'h0000_0000));
	endtask

	task automatic test_random_traffic(input int count, input logic [31:0] disk_size);
		set_disk_sectors(disk_size);
		repeat (count) send_request(random_request());
	endtask

	// Dirty every line so that one flush has to write back the whole cache.
	task automatic test_full_flush();
		for (int i = 0; i < sclc_pkg::LINES; i++) begin
			if (cached[i])
				send_request(make_request(sclc_pkg::OP_WRITE, tag_device[i], tag_sector[i]));
			else
				send_request(make_request(sclc_pkg::OP_WRITE, 2'($urandom_range(3)),
					$urandom()));
		end
		send_request(make_request(sclc_pkg::OP_FLUSH, 2'($urandom_range(3)), $urandom()));
	endtask

	task automatic test_backpressure();
		set_disk_sectors($urandom());
		rsp_holdoff_request = HOLDOFF_CYCLES;
		repeat (12) send_request(random_request());
	endtask

	task automatic test_no_idle();
		set_disk_sectors(32'hFFFF_FFFF);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		repeat (40) send_request(random_request());
		req_idle_pct = 33;
		rsp_idle_pct = 33;
	endtask

	initial begin
		for (int k = 0; k < POOL; k++) begin
			pool_device[k] = 2'($urandom_range(3));
			pool_sector[k] = (k % 2 == 1) ? $urandom() : $urandom_range(4095);
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_traffic(30, 32'd2048);
		test_full_flush();
		test_backpressure();
		test_no_idle();
		test_random_traffic(10, $urandom());
		drain_results();
		$display("covered %0d requests and %0d result beats: %0d hits, %0d misses",
			n_requests, n_beats, n_hits, n_misses);
		$display("%0d eviction write-backs, %0d flush beats, %0d prefetches past the disk end",
			n_evict_writebacks, n_flush_beats, n_skipped);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sector_cache_lru_controller.f
hw/rtl/sclc_pkg.sv
hw/rtl/sector_cache_lru_controller.sv
tb/sv/testbench.sv
